/* hdl/rpb_pkg.sv */
// Shared constants and helpers for the RGBA pixel blend unit.
// No dependencies; used by rpb_chan, rpb_datapath and rgb_pixel_blend_unit.
package rpb_pkg;

    // Pixel layout
    localparam int CHAN_W    = 8;
    localparam int NUM_CHAN  = 4;
    localparam int PIXEL_W   = CHAN_W * NUM_CHAN;

    // Configuration port
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_BLEND_MODE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_MIX_WEIGHT = CFG_IDX_W'(1);

    localparam logic [CHAN_W-1:0] MODE_RESET   = 8'd0;
    localparam logic [CHAN_W-1:0] WEIGHT_RESET = 8'd128;

    // Blend mode codes; every other value selects replace
    localparam logic [CHAN_W-1:0] MODE_ADD     = 8'd1;
    localparam logic [CHAN_W-1:0] MODE_MAX     = 8'd2;
    localparam logic [CHAN_W-1:0] MODE_AVG     = 8'd3;
    localparam logic [CHAN_W-1:0] MODE_SUB_DS  = 8'd4;
    localparam logic [CHAN_W-1:0] MODE_SUB_SD  = 8'd5;
    localparam logic [CHAN_W-1:0] MODE_MUL     = 8'd6;
    localparam logic [CHAN_W-1:0] MODE_MIX     = 8'd7;
    localparam logic [CHAN_W-1:0] MODE_XOR     = 8'd8;
    localparam logic [CHAN_W-1:0] MODE_MIN     = 8'd9;

    localparam logic [CHAN_W-1:0] CHAN_MAX = 8'hFF;

    // Exact floor(p / 255) for any product of two 8-bit channel values
    function automatic logic [CHAN_W-1:0] div255(input logic [2*CHAN_W-1:0] p);
        logic [2*CHAN_W:0] t;
        t = {1'b0, p} + {9'd0, p[2*CHAN_W-1:CHAN_W]} + 17'd1;
        return t[2*CHAN_W-1:CHAN_W];
    endfunction

endpackage

/* hdl/rpb_chan.sv */
// One 8-bit channel lane of the blend datapath.
// Depends on rpb_pkg for mode codes and the divide-by-255 helper.
module rpb_chan (
    input  logic [rpb_pkg::CHAN_W-1:0] mode,
    input  logic [rpb_pkg::CHAN_W-1:0] weight,
    input  logic [rpb_pkg::CHAN_W-1:0] dst,
    input  logic [rpb_pkg::CHAN_W-1:0] src,
    output logic [rpb_pkg::CHAN_W-1:0] result
);

    logic [rpb_pkg::CHAN_W:0]     sum;
    logic [rpb_pkg::CHAN_W-1:0]   inv_weight;
    logic [rpb_pkg::CHAN_W-1:0]   mul_b;
    logic [2*rpb_pkg::CHAN_W-1:0] prod_a;
    logic [2*rpb_pkg::CHAN_W-1:0] prod_b;
    logic [rpb_pkg::CHAN_W:0]     mix_sum;
    logic                         dst_gt;

    // Shared multiplier: a*s for multiply, a*w for mix
    always_comb begin
        inv_weight = rpb_pkg::CHAN_MAX - weight;
        mul_b      = (mode == rpb_pkg::MODE_MIX) ? weight : src;
        prod_a     = {8'd0, dst} * {8'd0, mul_b};
        prod_b     = {8'd0, src} * {8'd0, inv_weight};
        mix_sum    = {1'b0, rpb_pkg::div255(prod_a)} + {1'b0, rpb_pkg::div255(prod_b)};
        sum        = {1'b0, dst} + {1'b0, src};
        dst_gt     = dst > src;
    end

    // Select the per-channel operation
    always_comb begin
        unique case (mode)
            rpb_pkg::MODE_ADD:    result = sum[rpb_pkg::CHAN_W] ? rpb_pkg::CHAN_MAX
                                                                : sum[rpb_pkg::CHAN_W-1:0];
            rpb_pkg::MODE_MAX:    result = dst_gt ? dst : src;
            rpb_pkg::MODE_AVG:    result = (dst >> 1) + (src >> 1);
            rpb_pkg::MODE_SUB_DS: result = dst_gt ? dst - src : '0;
            rpb_pkg::MODE_SUB_SD: result = (src > dst) ? src - dst : '0;
            rpb_pkg::MODE_MUL:    result = rpb_pkg::div255(prod_a);
            rpb_pkg::MODE_MIX:    result = mix_sum[rpb_pkg::CHAN_W-1:0];
            rpb_pkg::MODE_MIN:    result = dst_gt ? src : dst;
            default:              result = src;
        endcase
    end

endmodule

/* hdl/rpb_datapath.sv */
// Combinational blend of one pixel: four channel lanes plus word-wide modes.
// Depends on rpb_pkg and rpb_chan.
module rpb_datapath (
    input  logic [rpb_pkg::CHAN_W-1:0]  mode,
    input  logic [rpb_pkg::CHAN_W-1:0]  weight,
    input  logic [rpb_pkg::PIXEL_W-1:0] dst,
    input  logic [rpb_pkg::PIXEL_W-1:0] src,
    output logic [rpb_pkg::PIXEL_W-1:0] pixel
);

    localparam int TOP = rpb_pkg::NUM_CHAN - 1;

    logic [rpb_pkg::PIXEL_W-1:0] lane_out;
    logic                        clear_top;

    // One lane per channel
    for (genvar k = 0; k < rpb_pkg::NUM_CHAN; k++) begin : g_lane
        rpb_chan u_chan (
            .mode   (mode),
            .weight (weight),
            .dst    (dst[k*rpb_pkg::CHAN_W +: rpb_pkg::CHAN_W]),
            .src    (src[k*rpb_pkg::CHAN_W +: rpb_pkg::CHAN_W]),
            .result (lane_out[k*rpb_pkg::CHAN_W +: rpb_pkg::CHAN_W])
        );
    end

    // Drop the top byte for the three-channel modes; handle word modes
    always_comb begin
        clear_top = (mode == rpb_pkg::MODE_MAX) || (mode == rpb_pkg::MODE_MIN) ||
                    (mode == rpb_pkg::MODE_MUL) || (mode == rpb_pkg::MODE_MIX);
        pixel = lane_out;
        if (clear_top) begin
            pixel[TOP*rpb_pkg::CHAN_W +: rpb_pkg::CHAN_W] = '0;
        end
        if (mode == rpb_pkg::MODE_XOR) begin
            pixel = dst ^ src;
        end
    end

endmodule

/* hdl/rgb_pixel_blend_unit.sv */
// RGBA8888 blend unit: input register, combinational blend, result register.
// The input and result registers are the two register stages; a request is blended between them.
// Throughput: one pixel per cycle while m_ready holds; the input and result registers form a
// two-stage valid/ready pipeline around the single blend stage.
// Reset (aresetn, synchronous, active low) empties both stages and sets
// blend_mode to replace and mix_weight to 128. Depends on rpb_pkg, rpb_datapath.
module rgb_pixel_blend_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Configuration write port
    input  logic                              cfg_we,
    input  logic [rpb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rpb_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    // Input requests
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [rpb_pkg::PIXEL_W-1:0]       s_dest_pixel,
    input  logic [rpb_pkg::PIXEL_W-1:0]       s_source_color,
    // Result requests
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [rpb_pkg::PIXEL_W-1:0]       m_blended_pixel
);

    logic [rpb_pkg::CHAN_W-1:0]  mode_reg;
    logic [rpb_pkg::CHAN_W-1:0]  weight_reg;
    logic                        in_valid_reg;
    logic [rpb_pkg::PIXEL_W-1:0] dst_reg;
    logic [rpb_pkg::PIXEL_W-1:0] src_reg;
    logic                        out_valid_reg;
    logic [rpb_pkg::PIXEL_W-1:0] out_pixel_reg;
    logic [rpb_pkg::PIXEL_W-1:0] pixel_next;
    logic                        out_advance;
    logic                        in_accept;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= rpb_pkg::MODE_RESET;
            weight_reg <= rpb_pkg::WEIGHT_RESET;
        end else if (cfg_we) begin
            if (cfg_index == rpb_pkg::REG_BLEND_MODE) begin
                mode_reg <= cfg_wdata;
            end
            if (cfg_index == rpb_pkg::REG_MIX_WEIGHT) begin
                weight_reg <= cfg_wdata;
            end
        end
    end

    // Handshake: advance each stage when the one after it can take a request
    assign out_advance = !out_valid_reg || m_ready;
    assign s_ready     = !in_valid_reg || out_advance;
    assign in_accept   = s_valid && s_ready;

    // Input stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            dst_reg <= s_dest_pixel;
            src_reg <= s_source_color;
        end
    end

    // Blend
    rpb_datapath u_datapath (
        .mode   (mode_reg),
        .weight (weight_reg),
        .dst    (dst_reg),
        .src    (src_reg),
        .pixel  (pixel_next)
    );

    // Result stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_advance && in_valid_reg) begin
            out_pixel_reg <= pixel_next;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_blended_pixel = out_pixel_reg;

`ifndef SYNTHESIS
    // Reset empties both stages
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !in_valid_reg && !out_valid_reg)
        else $error("pipeline not empty after reset");

    // An accepted request lands in the input stage
    a_accept_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept |=> in_valid_reg && dst_reg == $past(s_dest_pixel)
                      && src_reg == $past(s_source_color))
        else $error("accepted request not captured");

    // A stalled input stage holds its request
    a_input_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !out_advance |=> in_valid_reg && $stable(dst_reg)
                                        && $stable(src_reg))
        else $error("stalled input stage lost its request");

    // A request moving forward shows up as the blended result
    a_result_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && out_advance |=> m_valid
                                      && m_blended_pixel == $past(pixel_next))
        else $error("blend result not transferred");

    // Input stage only empties by moving forward
    a_no_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !out_advance |-> !s_ready)
        else $error("input stage open while holding a stalled request");
`endif

endmodule
